// ===== rtl/core/lock_order_deadlock_detector_assert.svh =====
// Assertion macros used by the checker file of the lock-order detector.
// Each macro takes a label, an antecedent and a consequent, and is sampled
// on clk_i with reset rst_ni low disabling the check.
`ifndef LOCK_ORDER_DEADLOCK_DETECTOR_ASSERT_SVH
`define LOCK_ORDER_DEADLOCK_DETECTOR_ASSERT_SVH

// Same-cycle implication.
`define LODD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lock order detector: assertion failed");

// Next-cycle implication.
`define LODD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lock order detector: assertion failed");

`endif

// ===== rtl/core/lodd_pkg.sv =====
// ----------------------------------------------------------------------------
// lodd_pkg
// Codes shared by the lock-order deadlock detector and its checker.
// ----------------------------------------------------------------------------
package lodd_pkg;

  // Action of an input word
  localparam logic ActAcquire = 1'b0;
  localparam logic ActRelease = 1'b1;

  // Result status codes
  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StDeadlock = 3'd1;
  localparam logic [2:0] StEmpty    = 3'd2;
  localparam logic [2:0] StNotTop   = 3'd3;
  localparam logic [2:0] StFull     = 3'd4;
  localparam logic [2:0] StHalted   = 3'd5;

  // Widths of the word fields
  localparam int unsigned IdW     = 5;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CountW  = 5;

endpackage

// ===== rtl/core/lock_order_deadlock_detector.sv =====
// ----------------------------------------------------------------------------
// lock_order_deadlock_detector
// Tracks held locks on a stack and the lock-order graph in a bit matrix, and
// flags an acquire whose new ordering edge closes a cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Input: raise start with action_i and lock_id_i; the word is taken at a
//   rising edge where busy is low. busy stays high until the result.
//   Output: done_o is high for exactly one cycle with status_o, edge_from_o,
//   edge_to_o and held_count_o; the receiver cannot stall it.
// Sequence: STop checks the word against the stack top; releases, halted,
//   ignored and full items and acquires that add no edge finish there.
//   Otherwise SRow reads the top lock's row and finishes if the edge is
//   known; a new edge is written and walked in SWalk and SWend, sweeping
//   the matrix rows until the top lock is reached or no row is new.
//   The walk is set by the single read port of the graph memory, one row
//   per cycle. A new word may be started in the cycle done_o is shown.
// Reset: stack empty, graph cleared at once through per-row valid bits,
//   halt flag cleared. After a deadlock every word returns halted until reset.
// ----------------------------------------------------------------------------
module lock_order_deadlock_detector #(
  parameter int unsigned MAX_LOCKS   = 32,
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         action_i,
  input  logic [lodd_pkg::IdW-1:0]     lock_id_i,
  output logic                         done_o,
  output logic [lodd_pkg::StatusW-1:0] status_o,
  output logic [lodd_pkg::IdW-1:0]     edge_from_o,
  output logic [lodd_pkg::IdW-1:0]     edge_to_o,
  output logic [lodd_pkg::CountW-1:0]  held_count_o
);

  localparam int unsigned NodeW = (MAX_LOCKS > 1) ? $clog2(MAX_LOCKS) : 1;
  localparam int unsigned SIdxW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned SpW   = $clog2(STACK_DEPTH + 1);

  // Sequencer codes
  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] STop  = 3'd1;
  localparam logic [2:0] SRow  = 3'd2;
  localparam logic [2:0] SWalk = 3'd3;
  localparam logic [2:0] SWend = 3'd4;

  logic [2:0] state_q, state_d;

  // Captured word
  logic                     act_q;
  logic [lodd_pkg::IdW-1:0] id_q;
  logic [lodd_pkg::IdW-1:0] top_q;
  logic [NodeW-1:0]         id_node;
  logic [NodeW-1:0]         top_node;
  logic                     id_oor;

  // Stack memory
  logic [lodd_pkg::IdW-1:0] stack_mem [STACK_DEPTH];
  logic [lodd_pkg::IdW-1:0] st_rdata_q;
  logic [SpW-1:0]           sp_q, sp_d;
  logic [SIdxW-1:0]         st_raddr;
  logic                     st_re;
  logic                     push, pop;

  // Graph memory with per-row valid bits
  logic [MAX_LOCKS-1:0] graph_mem [MAX_LOCKS];
  logic [MAX_LOCKS-1:0] row_vld_q;
  logic [MAX_LOCKS-1:0] gr_rdata_q;
  logic                 gr_rvld_q;
  logic [MAX_LOCKS-1:0] row_eff;
  logic [NodeW-1:0]     gr_raddr;
  logic                 gr_re;
  logic                 gr_we;

  // Reachability walk
  logic [MAX_LOCKS-1:0] vis_q, vis_d;
  logic [NodeW-1:0]     idx_q;
  logic [NodeW-1:0]     pend_idx_q;
  logic                 pend_q;
  logic                 chg_q;
  logic [MAX_LOCKS-1:0] new_bits;
  logic                 walk_start;

  // Finish of a word
  logic                         fin;
  logic [lodd_pkg::StatusW-1:0] fin_st;
  logic                         dead;
  logic                         halted_q;

  assign id_node  = NodeW'(id_q);
  assign top_node = NodeW'(top_q);
  assign id_oor   = (32'(id_q) >= MAX_LOCKS);
  assign row_eff  = gr_rvld_q ? gr_rdata_q : '0;
  assign st_raddr = SIdxW'(sp_q - SpW'(1));
  assign st_re    = start && (state_q == SIdle);

  // Rows newly reached through the row that arrives this cycle
  assign new_bits = (pend_q && vis_q[pend_idx_q]) ? (row_eff & ~vis_q) : '0;
  assign vis_d    = vis_q | new_bits;

  // Graph read address: the top row, then the sweep index
  assign gr_raddr = (state_q == STop) ? NodeW'(st_rdata_q) : idx_q;

  // Sequencer
  always_comb begin
    state_d    = state_q;
    fin        = 1'b0;
    fin_st     = lodd_pkg::StOk;
    push       = 1'b0;
    pop        = 1'b0;
    dead       = 1'b0;
    gr_re      = 1'b0;
    gr_we      = 1'b0;
    walk_start = 1'b0;
    unique case (state_q)
      SIdle: begin
        if (start) state_d = STop;
      end
      STop: begin
        fin = 1'b1;
        if (halted_q) begin
          fin_st = lodd_pkg::StHalted;
        end else if (id_oor) begin
          fin_st = lodd_pkg::StOk;
        end else if (act_q == lodd_pkg::ActRelease) begin
          if (sp_q == '0) fin_st = lodd_pkg::StEmpty;
          else if (st_rdata_q != id_q) fin_st = lodd_pkg::StNotTop;
          else pop = 1'b1;
        end else if (32'(sp_q) >= STACK_DEPTH) begin
          fin_st = lodd_pkg::StFull;
        end else if (sp_q == '0 || st_rdata_q == id_q) begin
          push = 1'b1;
        end else begin
          fin   = 1'b0;
          gr_re = 1'b1;
          state_d = SRow;
        end
      end
      SRow: begin
        if (row_eff[id_node]) begin
          fin  = 1'b1;
          push = 1'b1;
        end else begin
          gr_we      = 1'b1;
          walk_start = 1'b1;
          state_d    = SWalk;
        end
      end
      SWalk: begin
        gr_re = 1'b1;
        if (idx_q == NodeW'(MAX_LOCKS - 1)) state_d = SWend;
      end
      SWend: begin
        if (vis_d[top_node]) begin
          fin    = 1'b1;
          dead   = 1'b1;
          fin_st = lodd_pkg::StDeadlock;
        end else if (chg_q || (new_bits != '0)) begin
          state_d = SWalk;
        end else begin
          fin  = 1'b1;
          push = 1'b1;
        end
      end
      default: state_d = SIdle;
    endcase
    if (fin) state_d = SIdle;
  end

  always_comb begin
    sp_d = sp_q;
    if (push) sp_d = sp_q + SpW'(1);
    else if (pop) sp_d = sp_q - SpW'(1);
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      sp_q      <= '0;
      halted_q  <= 1'b0;
      row_vld_q <= '0;
      vis_q     <= '0;
      idx_q     <= '0;
      pend_q    <= 1'b0;
      chg_q     <= 1'b0;
      done_o    <= 1'b0;
    end else begin
      state_q <= state_d;
      sp_q    <= sp_d;
      done_o  <= fin;
      pend_q  <= (state_q == SWalk);
      if (dead) halted_q <= 1'b1;
      if (gr_we) row_vld_q[top_node] <= 1'b1;
      // sweep bookkeeping
      if (walk_start) begin
        vis_q    <= MAX_LOCKS'(1) << id_node;
        idx_q    <= '0;
        chg_q    <= 1'b0;
      end else if (state_q == SWalk) begin
        vis_q <= vis_d;
        idx_q <= idx_q + NodeW'(1);
        if (new_bits != '0) chg_q <= 1'b1;
      end else if (state_q == SWend) begin
        vis_q <= vis_d;
        idx_q <= '0;
        chg_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (st_re) begin
      act_q <= action_i;
      id_q  <= lock_id_i;
    end
    if (state_q == STop) top_q <= st_rdata_q;
    if (state_q == SWalk) pend_idx_q <= idx_q;
    if (fin) begin
      status_o     <= fin_st;
      edge_from_o  <= dead ? top_q : '0;
      edge_to_o    <= dead ? id_q : '0;
      held_count_o <= lodd_pkg::CountW'(sp_d);
    end
  end

  // Held-lock stack memory
  always_ff @(posedge clk_i) begin
    if (push) stack_mem[SIdxW'(sp_q)] <= id_q;
    if (st_re) st_rdata_q <= stack_mem[st_raddr];
  end

  // Lock-order graph memory; a row not yet written reads as empty
  always_ff @(posedge clk_i) begin
    if (gr_we) graph_mem[top_node] <= row_eff | (MAX_LOCKS'(1) << id_node);
    if (gr_re) begin
      gr_rdata_q <= graph_mem[gr_raddr];
      gr_rvld_q  <= row_vld_q[gr_raddr];
    end
  end

  assign busy = (state_q != SIdle);

endmodule

// ===== rtl/core/lodd_checker.sv =====
// ----------------------------------------------------------------------------
// lodd_checker
// Port-level checks of the lock-order deadlock detector, bound to the top.
// ----------------------------------------------------------------------------
`include "lock_order_deadlock_detector_assert.svh"

module lodd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic                         busy,
  input logic                         done_o,
  input logic [lodd_pkg::StatusW-1:0] status_o,
  input logic [lodd_pkg::IdW-1:0]     edge_from_o,
  input logic [lodd_pkg::IdW-1:0]     edge_to_o
);

  // An accepted word keeps the block busy in the next cycle
  `LODD_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

  // A result word never follows straight after another
  `LODD_ASSERT_NEXT(a_done_single, done_o, !done_o)

  // Only defined status codes are reported
  `LODD_ASSERT_NOW(a_status_code, done_o, status_o <= lodd_pkg::StHalted)

  // Edge fields are zero unless a deadlock is reported
  `LODD_ASSERT_NOW(a_edge_zero, done_o && (status_o != lodd_pkg::StDeadlock), (edge_from_o == '0) && (edge_to_o == '0))

endmodule

bind lock_order_deadlock_detector lodd_checker u_lodd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .done_o      (done_o),
  .status_o    (status_o),
  .edge_from_o (edge_from_o),
  .edge_to_o   (edge_to_o)
);
